// ===== hdl/lfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lfr_pkg: shared types and constants of the luma frame rotator
// Holds the beat types of both channels, the configuration bundle, the
// command that travels from the front end to the back end, and the codes
// and helper functions used by more than one file.
// ----------------------------------------------------------------------------
package lfr_pkg;

  // Fixed widths of the frame geometry.
  localparam int WORD_W = 32;  // one word holds four 8-bit pixels
  localparam int DIM_W  = 9;   // width_groups / height_groups, 1..256
  localparam int ROW_W  = 10;  // destination row, below 1024
  localparam int COL_W  = 8;   // destination column, below 256
  localparam int IDX_W  = 18;  // word index inside a frame, below 262144
  localparam int TOT_W  = 19;  // word count of a frame, up to 262144
  localparam int CMP_W  = 21;  // range compare against the store capacity
  localparam int QDEPTH = 2;   // command queue depth

  // Operation carried by an input beat.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  // Rotation modes.
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_ROT270 = 2'd1;
  localparam logic [1:0] MODE_ROT180 = 2'd2;
  localparam logic [1:0] MODE_ROT90  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Configuration reset values.
  localparam logic [DIM_W-1:0] RESET_WIDTH  = 9'd80;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 9'd60;

  // Back-end command kinds.
  localparam logic [1:0] CMD_WRITE  = 2'd0;  // store one source word
  localparam logic [1:0] CMD_COPY   = 2'd1;  // read one word as is
  localparam logic [1:0] CMD_FLIP   = 2'd2;  // read one word, bytes reversed
  localparam logic [1:0] CMD_GATHER = 2'd3;  // one byte from each of four words

  // Byte lane masks.
  localparam logic [WORD_W-1:0] BYTE3_MASK = 32'hFF000000;
  localparam logic [WORD_W-1:0] BYTE2_MASK = 32'h00FF0000;
  localparam logic [WORD_W-1:0] BYTE1_MASK = 32'h0000FF00;
  localparam logic [WORD_W-1:0] BYTE0_MASK = 32'h000000FF;

  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] source_word;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] dest_word;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       rotation_mode;
    logic [DIM_W-1:0] width_groups;
    logic [DIM_W-1:0] height_groups;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [IDX_W-1:0]  addr;    // first word index
    logic [DIM_W-1:0]  stride;  // index step between gathered words
    logic [1:0]        lane;    // source byte picked by a gather
    logic [WORD_W-1:0] data;    // word to store
    logic              last;
  } cmd_t;

  // Dimensions of zero act as one, those above 256 act as 256.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v[DIM_W-1] && (v[DIM_W-2:0] != '0)) begin
      r = DIM_W'(256);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Reverse the four pixels of a word.
  function automatic logic [WORD_W-1:0] byte_swap(input logic [WORD_W-1:0] w);
    return ((w & BYTE3_MASK) >> 24) | ((w & BYTE2_MASK) >> 8)
         | ((w & BYTE1_MASK) << 8)  | ((w & BYTE0_MASK) << 24);
  endfunction

endpackage

// ===== hdl/luma_frame_rotator_unit.sv =====
// ----------------------------------------------------------------------------
// luma_frame_rotator_unit: 8-bit luma frame rotation by 0, 90, 180, 270 deg
// Load beats fill a frame store of 32-bit words; emit beats return the
// rotated frame word by word in row-major order with a last flag.
// ----------------------------------------------------------------------------
// The front end takes one input beat at a time (capture, frame size
// product, address product, queue push) and hands a command through a
// two-entry queue to the back end. The back end stores a load without
// leaving idle; a straight or 180 degree emit reads one word and a 90 or
// 270 degree emit reads four, which come one at a time through the single
// port of the frame memory. No new command is taken until the result is in
// the output register. The store holds FRAME_WORDS words and is not cleared
// after reset; read only words that were loaded.
module luma_frame_rotator_unit import lfr_pkg::*; #(
  parameter int FRAME_WORDS = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_wdata
);

  cfg_t cfg;
  cmd_t push_cmd;
  logic push_valid;
  logic push_ready;
  cmd_t pop_cmd;
  logic pop_valid;
  logic pop_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation_mode <= MODE_NONE;
      cfg.width_groups  <= RESET_WIDTH;
      cfg.height_groups <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   cfg.rotation_mode <= cfg_wdata[1:0];
        REG_WIDTH:  cfg.width_groups  <= cfg_wdata;
        REG_HEIGHT: cfg.height_groups <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  lfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_data    (in_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cfg        (cfg),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  lfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  lfr_back #(
    .FRAME_WORDS (FRAME_WORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_cmd   (pop_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  // The front end works on one beat at a time.
  a_front_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("front end took a beat while still busy");

  // A command blocked by a full queue is offered again unchanged.
  a_push_hold: assert property (@(posedge clk) disable iff (rst)
    push_valid && !push_ready |=> push_valid && $stable(push_cmd))
    else $error("front end command changed while stalled");

  // Starting a read keeps the back end off the queue for the next cycle.
  a_back_busy: assert property (@(posedge clk) disable iff (rst)
    pop_valid && pop_ready && (pop_cmd.kind != CMD_WRITE) |=> !pop_ready)
    else $error("back end popped a command during a read");

endmodule

// ===== hdl/lfr_front.sv =====
// ----------------------------------------------------------------------------
// lfr_front: input beat classification and address generation
// Takes one input beat at a time, keeps the load and emit pointers, works
// out the frame size and the source word addresses with a single shared
// multiplier, and pushes one command per beat into the command queue.
// ----------------------------------------------------------------------------
module lfr_front import lfr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  in_item_t in_data,
  input  logic     in_valid,
  output logic     in_ready,
  input  cfg_t     cfg,
  output cmd_t     push_cmd,
  output logic     push_valid,
  input  logic     push_ready
);

  localparam logic [1:0] F_IDLE = 2'd0;  // waiting for a beat
  localparam logic [1:0] F_DIM  = 2'd1;  // frame size product
  localparam logic [1:0] F_ADDR = 2'd2;  // address product
  localparam logic [1:0] F_PUSH = 2'd3;  // hand the command to the queue

  logic [1:0]        state;
  logic              op_q;
  logic [WORD_W-1:0] src_q;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  prod;
  logic [IDX_W-1:0]  load_pointer;
  logic [ROW_W-1:0]  emit_row;
  logic [COL_W-1:0]  emit_col;

  logic [DIM_W-1:0]  cw;
  logic [DIM_W-1:0]  hg;
  logic [ROW_W:0]    rows;
  logic              emit_wrap;
  logic [ROW_W-1:0]  r_eff;
  logic [COL_W-1:0]  c_eff;
  logic [DIM_W-1:0]  col_mirror;
  logic [ROW_W-1:0]  col4;
  logic [ROW_W-1:0]  mult_a;
  logic [DIM_W-1:0]  mult_b;
  logic [TOT_W-1:0]  mult_p;

  logic [IDX_W-1:0]  lp_eff;
  logic [TOT_W-1:0]  lp_inc;
  logic [IDX_W-1:0]  lp_next;
  logic [TOT_W-1:0]  n_lin;
  logic [TOT_W-1:0]  addr_w;
  logic [ROW_W:0]    row_inc;
  logic [COL_W:0]    col_inc;
  logic [1:0]        kind;
  logic [1:0]        lane;

  // Clamped geometry from the configuration registers.
  assign cw   = clamp_dim(cfg.width_groups);
  assign hg   = clamp_dim(cfg.height_groups);
  assign rows = {hg, 2'b00};

  // An emit position left outside the frame by a size change restarts at zero.
  assign emit_wrap = ({1'b0, emit_row} >= rows) || ({1'b0, emit_col} >= cw);
  assign r_eff     = emit_wrap ? '0 : emit_row;
  assign c_eff     = emit_wrap ? '0 : emit_col;

  // Shared multiplier: width times height groups for the frame size, then
  // row times width for straight and 180 degree reads, or source column
  // group times height for the quarter turns.
  assign col_mirror = cw - DIM_W'(1) - DIM_W'(c_eff);
  assign col4 = (cfg.rotation_mode == MODE_ROT90) ? {c_eff, 2'b00}
                                                  : {col_mirror[COL_W-1:0], 2'b00};

  always_comb begin
    if (state == F_DIM) begin
      mult_a = ROW_W'(cw);
      mult_b = hg;
    end else if (cfg.rotation_mode inside {MODE_ROT270, MODE_ROT90}) begin
      mult_a = col4;
      mult_b = hg;
    end else begin
      mult_a = r_eff;
      mult_b = cw;
    end
  end

  assign mult_p = TOT_W'(mult_a) * TOT_W'(mult_b);

  // Load pointer with restart and wrap.
  assign lp_eff  = ({1'b0, load_pointer} >= total) ? '0 : load_pointer;
  assign lp_inc  = TOT_W'(lp_eff) + TOT_W'(1);
  assign lp_next = (lp_inc >= total) ? '0 : lp_inc[IDX_W-1:0];

  // Emit position advance.
  assign row_inc = {1'b0, emit_row} + (ROW_W+1)'(1);
  assign col_inc = {1'b0, emit_col} + (COL_W+1)'(1);

  // First source word of the destination word, by mode.
  assign n_lin = prod + TOT_W'(emit_col);

  always_comb begin
    case (cfg.rotation_mode)
      MODE_NONE: begin
        addr_w = n_lin;
        kind   = CMD_COPY;
        lane   = 2'd0;
      end
      MODE_ROT180: begin
        addr_w = total - TOT_W'(1) - n_lin;
        kind   = CMD_FLIP;
        lane   = 2'd0;
      end
      MODE_ROT90: begin
        addr_w = prod + TOT_W'(hg) - TOT_W'(1) - TOT_W'(emit_row[ROW_W-1:2]);
        kind   = CMD_GATHER;
        lane   = emit_row[1:0];
      end
      default: begin
        addr_w = prod + TOT_W'(emit_row[ROW_W-1:2]);
        kind   = CMD_GATHER;
        lane   = ~emit_row[1:0];
      end
    endcase
  end

  // Command toward the back end.
  always_comb begin
    push_cmd.data   = src_q;
    push_cmd.stride = hg;
    if (op_q == OP_LOAD) begin
      push_cmd.kind = CMD_WRITE;
      push_cmd.addr = lp_eff;
      push_cmd.lane = 2'd0;
      push_cmd.last = 1'b0;
    end else begin
      push_cmd.kind = kind;
      push_cmd.addr = addr_w[IDX_W-1:0];
      push_cmd.lane = lane;
      push_cmd.last = (row_inc == rows) && (col_inc == cw);
    end
  end

  assign in_ready   = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);

  // Sequencer and pointer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      load_pointer <= '0;
      emit_row     <= '0;
      emit_col     <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            state <= F_DIM;
          end
        end
        F_DIM: begin
          state <= F_ADDR;
        end
        F_ADDR: begin
          if (op_q == OP_EMIT) begin
            emit_row <= r_eff;
            emit_col <= c_eff;
          end
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) begin
            if (op_q == OP_LOAD) begin
              load_pointer <= lp_next;
            end else if (col_inc >= cw) begin
              emit_col <= '0;
              emit_row <= (row_inc >= rows) ? '0 : row_inc[ROW_W-1:0];
            end else begin
              emit_col <= col_inc[COL_W-1:0];
            end
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  // Beat capture and product registers.
  always_ff @(posedge clk) begin
    if ((state == F_IDLE) && in_valid) begin
      op_q  <= in_data.op;
      src_q <= in_data.source_word;
    end
    if (state == F_DIM) begin
      total <= {mult_p[TOT_W-3:0], 2'b00};
    end
    if (state == F_ADDR) begin
      prod <= mult_p;
    end
  end

endmodule

// ===== hdl/lfr_queue.sv =====
// ----------------------------------------------------------------------------
// lfr_queue: command queue between front end and back end
// A small register FIFO that lets either side stall without holding up
// the other.
// ----------------------------------------------------------------------------
module lfr_queue import lfr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t push_cmd,
  input  logic push_valid,
  output logic push_ready,
  output cmd_t pop_cmd,
  output logic pop_valid,
  input  logic pop_ready
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          entries [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push_fire;
  logic          pop_fire;

  assign push_ready = (count != CW'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push_fire && !pop_fire) begin
        count <= count + CW'(1);
      end else if (pop_fire && !push_fire) begin
        count <= count - CW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== hdl/lfr_back.sv =====
// ----------------------------------------------------------------------------
// lfr_back: frame store and result assembly
// Executes queued commands against a single-port frame memory: stores
// loaded words, reads one word for straight and 180 degree output, or
// gathers one byte from each of four words for the quarter turns, and
// holds the finished word in the output register.
// ----------------------------------------------------------------------------
module lfr_back import lfr_pkg::*; #(
  parameter int FRAME_WORDS = 65536
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      pop_cmd,
  input  logic      pop_valid,
  output logic      pop_ready,
  output out_item_t out_data,
  output logic      out_valid,
  input  logic      out_ready
);

  localparam int AW = $clog2(FRAME_WORDS);

  localparam logic [1:0] B_IDLE   = 2'd0;  // take the next command
  localparam logic [1:0] B_GATHER = 2'd1;  // collect read data
  localparam logic [1:0] B_HOLD   = 2'd2;  // wait for the output register

  logic [WORD_W-1:0] mem [FRAME_WORDS];
  logic [WORD_W-1:0] rd_data;
  logic              rd_ok;

  logic [1:0]        state;
  logic [1:0]        kind_q;
  logic [1:0]        lane_q;
  logic [DIM_W-1:0]  stride_q;
  logic              last_q;
  logic [IDX_W-1:0]  cur_addr;
  logic [1:0]        beat;
  logic [WORD_W-1:0] acc;

  logic              pop_fire;
  logic [IDX_W-1:0]  acc_addr;
  logic [CMP_W-1:0]  addr_wide;
  logic              addr_ok;
  logic [AW-1:0]     mem_addr;
  logic              mem_we;
  logic              more_reads;
  logic              mem_re;
  logic [WORD_W-1:0] rd_word;
  logic [7:0]        picked;
  logic [WORD_W-1:0] gather_word;
  logic [WORD_W-1:0] final_word;
  logic              finish;
  logic              slot_free;
  logic              out_load;

  assign pop_ready = (state == B_IDLE);
  assign pop_fire  = pop_valid && pop_ready;

  // One memory port: the queue head in idle, the running gather address after.
  assign acc_addr  = (state == B_IDLE) ? pop_cmd.addr : cur_addr;
  assign addr_wide = CMP_W'(acc_addr);
  assign addr_ok   = (addr_wide < CMP_W'(FRAME_WORDS));
  assign mem_addr  = addr_wide[AW-1:0];

  assign mem_we     = pop_fire && (pop_cmd.kind == CMD_WRITE) && addr_ok;
  assign more_reads = (state == B_GATHER) && (kind_q == CMD_GATHER) && (beat != 2'd3);
  assign mem_re     = (pop_fire && (pop_cmd.kind != CMD_WRITE)) || more_reads;

  // Words beyond the store capacity read as zero.
  assign rd_word = rd_ok ? rd_data : '0;
  assign picked  = rd_word[{lane_q, 3'b000} +: 8];

  always_comb begin
    gather_word = acc;
    gather_word[{beat, 3'b000} +: 8] = picked;
  end

  always_comb begin
    case (kind_q)
      CMD_COPY: final_word = rd_word;
      CMD_FLIP: final_word = byte_swap(rd_word);
      default:  final_word = gather_word;
    endcase
  end

  assign finish    = (state == B_GATHER) && ((kind_q != CMD_GATHER) || (beat == 2'd3));
  assign slot_free = !out_valid || out_ready;
  assign out_load  = (finish || (state == B_HOLD)) && slot_free;

  // Frame memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= pop_cmd.data;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  // Control state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop_fire && (pop_cmd.kind != CMD_WRITE)) begin
            state <= B_GATHER;
          end
        end
        B_GATHER: begin
          if (finish) begin
            if (slot_free) begin
              state <= B_IDLE;
            end else begin
              state <= B_HOLD;
            end
          end
        end
        B_HOLD: begin
          if (slot_free) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // Command fields, gather progress and output beat.
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_ok <= addr_ok;
    end
    if (pop_fire) begin
      kind_q   <= pop_cmd.kind;
      lane_q   <= pop_cmd.lane;
      stride_q <= pop_cmd.stride;
      last_q   <= pop_cmd.last;
      cur_addr <= pop_cmd.addr + IDX_W'(pop_cmd.stride);
      beat     <= 2'd0;
    end
    if (state == B_GATHER) begin
      acc <= final_word;
      if (more_reads) begin
        cur_addr <= cur_addr + IDX_W'(stride_q);
        beat     <= beat + 2'd1;
      end
      if (finish && slot_free) begin
        out_data.dest_word <= final_word;
        out_data.last      <= last_q;
      end
    end
    if ((state == B_HOLD) && slot_free) begin
      out_data.dest_word <= acc;
      out_data.last      <= last_q;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the luma frame rotator
// Drives load and emit beats through the valid/ready input channel, keeps
// its own shadow of the frame store, the pointers and the registers, and
// works out the rotated word for every emit beat the block accepts. Each
// output beat is compared field by field with the oldest outstanding
// prediction. The store is built small so that the capacity edge is cheap
// to reach; it is filled completely first, so no later read hits an entry
// that was never loaded.
// ----------------------------------------------------------------------------
module tb;
  import lfr_pkg::*;

  localparam int STORE_WORDS   = 1024;  // small frame store
  localparam int FILL_LOADS    = 1040;  // whole store plus a few dropped loads
  localparam int RANDOM_BEATS  = 850;
  localparam int QUIET_AFTER   = 700;   // no idling once this many are queued
  localparam int SETTLE_CYCLES = 24;    // covers a load still in the pipe
  localparam int LONG_HOLD     = 250;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = REG_MODE;
  logic [DIM_W-1:0] cfg_wdata = '0;

  // Beats waiting to be offered, and rotated words waiting to come out.
  in_item_t  pending_beats[$];
  out_item_t expected_words[$];

  // Shadow of the block: store, pointers and registers.
  logic [WORD_W-1:0] shadow_store [STORE_WORDS];
  int unsigned       load_ptr = 0;
  int unsigned       emit_row = 0;
  int unsigned       emit_col = 0;
  logic [1:0]        reg_mode   = MODE_NONE;
  logic [DIM_W-1:0]  reg_width  = RESET_WIDTH;
  logic [DIM_W-1:0]  reg_height = RESET_HEIGHT;

  // Traffic shaping shared between the sequence and the two ports.
  bit quiet = 1'b0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int tx_gap = 0;
  int rx_stall = 0;
  int rx_hold_req = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;
  bit in_took = 1'b0;

  // Run statistics.
  int errors = 0;
  int loads_taken = 0;
  int emits_taken = 0;
  int frame_ends = 0;
  int settings = 0;
  int mode_emits [4] = '{0, 0, 0, 0};

  luma_frame_rotator_unit #(.FRAME_WORDS(STORE_WORDS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock: 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // A zero dimension counts as one, anything above 256 as 256.
  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v);
    int unsigned d;
    d = v;
    if (d < 1) d = 1;
    if (d > 256) d = 256;
    return d;
  endfunction

  // Words past the end of the store read as zero.
  function automatic logic [WORD_W-1:0] store_word(input int unsigned idx);
    return (idx < STORE_WORDS) ? shadow_store[idx] : '0;
  endfunction

  // Applies one accepted beat to the shadow and queues the rotated word of an emit.
  function automatic void predict_rotation(input in_item_t b);
    int unsigned cw, hg, rows, total, r, c, n, q, k, j;
    logic [WORD_W-1:0] s, w;
    out_item_t res;
    cw = eff_dim(reg_width);
    hg = eff_dim(reg_height);
    rows = 4 * hg;
    total = cw * rows;
    if (b.op == OP_LOAD) begin
      // A register change can leave the pointer outside the frame.
      if (load_ptr >= total) load_ptr = 0;
      if (load_ptr < STORE_WORDS) shadow_store[load_ptr] = b.source_word;
      load_ptr = (load_ptr + 1 >= total) ? 0 : load_ptr + 1;
      loads_taken++;
    end else begin
      if (emit_row >= rows || emit_col >= cw) begin
        emit_row = 0;
        emit_col = 0;
      end
      r = emit_row;
      c = emit_col;
      n = r * cw + c;
      q = r / 4;
      k = r % 4;
      w = '0;
      case (reg_mode)
        MODE_NONE: begin
          w = store_word(n);
        end
        MODE_ROT180: begin
          s = store_word(total - 1 - n);
          for (j = 0; j < 4; j++) w[8*j +: 8] = s[8*(3-j) +: 8];
        end
        MODE_ROT90: begin
          for (j = 0; j < 4; j++) begin
            s = store_word((4 * c + j) * hg + (hg - 1 - q));
            w[8*j +: 8] = s[8*k +: 8];
          end
        end
        default: begin
          for (j = 0; j < 4; j++) begin
            s = store_word((4 * (cw - 1 - c) + j) * hg + q);
            w[8*j +: 8] = s[8*(3-k) +: 8];
          end
        end
      endcase
      res.dest_word = w;
      res.last = (r + 1 == rows) && (c + 1 == cw);
      expected_words.push_back(res);
      emits_taken++;
      mode_emits[reg_mode]++;
      // Row-major walk, wrapping after the final word.
      if (c + 1 >= cw) begin
        emit_col = 0;
        emit_row = (r + 1 >= rows) ? 0 : r + 1;
      end else begin
        emit_col = c + 1;
      end
    end
  endfunction

  // Predict on every accepted input beat and check every accepted output beat.
  always @(posedge clk) begin
    out_item_t want;
    in_took = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_took = 1'b1;
        predict_rotation(in_data);
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected output beat: dest_word %h last %b", out_data.dest_word,
                 out_data.last);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (out_data.dest_word !== want.dest_word) begin
            $error("dest_word mismatch: expected %h, actual %h", want.dest_word,
                   out_data.dest_word);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $error("last mismatch: expected %b, actual %b", want.last, out_data.last);
            errors++;
          end
          if (out_data.last === 1'b1) frame_ends++;
        end
      end
    end
  end

  // Input driver: offers the next pending beat, with random idle bursts between beats.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        in_data <= pending_beats.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < tx_idle_pct) tx_gap = $urandom_range(1, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: random stall bursts, plus a long hold when the sequence asks for one.
  always @(negedge clk) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen = rx_hold_req;
      rx_hold_left = LONG_HOLD;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_ready <= 1'b0;
    end else if (!rst && !quiet && $urandom_range(0, 99) < rx_idle_pct) begin
      rx_stall = $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void push_beat(input logic op, input logic [WORD_W-1:0] w);
    in_item_t b;
    b.op = op;
    b.source_word = w;
    pending_beats.push_back(b);
  endfunction

  // Mostly tiny frames, sometimes zero, the maximum, or values that clamp.
  function automatic logic [DIM_W-1:0] pick_dim();
    int sel;
    logic [DIM_W-1:0] d;
    sel = $urandom_range(0, 99);
    if (sel < 65) d = DIM_W'($urandom_range(1, 4));
    else if (sel < 75) d = '0;
    else if (sel < 80) d = DIM_W'(256);
    else if (sel < 88) d = DIM_W'($urandom_range(257, 511));
    else d = DIM_W'($urandom_range(5, 40));
    return d;
  endfunction

  // Register writes happen only while the block is idle.
  task automatic set_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_MODE:  reg_mode = val[1:0];
      REG_WIDTH: reg_width = val;
      default:   reg_height = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Holds the sequence until every beat is in and every word is out.
  task automatic settle();
    while (pending_beats.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stimulus sequence.
  initial begin
    int rand_beats;
    int phase;
    int cnt;
    int unsigned total;
    logic [1:0] m;
    logic [DIM_W-1:0] w_val, h_val;
    logic [1:0] dir_modes [3];

    dir_modes = '{MODE_ROT180, MODE_ROT90, MODE_ROT270};
    rand_beats = 0;
    phase = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill the whole store at the reset geometry; the tail of the fill runs
    // past the store and must be dropped. Then read the start of the first row back.
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    push_beat(OP_LOAD, 32'h0000_0000);
    push_beat(OP_LOAD, 32'hFFFF_FFFF);
    for (int i = 2; i < FILL_LOADS; i++) push_beat(OP_LOAD, $urandom());
    for (int i = 0; i < 24; i++) push_beat(OP_EMIT, $urandom());
    settle();
    settings++;

    // Directed: zero dimensions act as a 1x1 frame of four words, read back
    // once in every mode so that the last flag lands on each fourth word.
    set_reg(REG_MODE, DIM_W'(MODE_NONE));
    set_reg(REG_WIDTH, '0);
    set_reg(REG_HEIGHT, '0);
    push_beat(OP_LOAD, 32'h0000_0000);
    push_beat(OP_LOAD, 32'hFFFF_FFFF);
    push_beat(OP_LOAD, 32'h3322_1100);
    push_beat(OP_LOAD, 32'h7766_5544);
    for (int i = 0; i < 4; i++) push_beat(OP_EMIT, 32'h0000_0000);
    settle();
    settings++;
    foreach (dir_modes[i]) begin
      set_reg(REG_MODE, DIM_W'(dir_modes[i]));
      for (int e = 0; e < 4; e++) push_beat(OP_EMIT, 32'hFFFF_FFFF);
      settle();
      settings++;
    end

    // Random phases, each under its own register setting.
    while (rand_beats < RANDOM_BEATS) begin
      phase++;
      if (rand_beats >= QUIET_AFTER) quiet = 1'b1;
      case (phase)
        1: begin m = MODE_ROT90;   w_val = 9'd256; h_val = 9'd256; end
        2: begin m = MODE_ROT270;  w_val = 9'd256; h_val = 9'd1;   end
        3: begin m = MODE_ROT180;  w_val = 9'd511; h_val = 9'd300; end
        4: begin m = MODE_NONE;    w_val = 9'd1;   h_val = 9'd256; end
        5: begin m = MODE_ROT270;  w_val = 9'd3;   h_val = 9'd2;   end
        default: begin
          m = 2'($urandom_range(0, 3));
          w_val = pick_dim();
          h_val = pick_dim();
        end
      endcase
      // Early phases set every register; later ones change a random subset.
      if (phase <= 5 || $urandom_range(0, 2) == 0) begin
        set_reg(REG_MODE, {7'($urandom()), m});
        set_reg(REG_WIDTH, w_val);
        set_reg(REG_HEIGHT, h_val);
      end else begin
        if ($urandom_range(0, 1)) set_reg(REG_HEIGHT, h_val);
        set_reg(REG_MODE, {7'($urandom()), m});
        if ($urandom_range(0, 1)) set_reg(REG_WIDTH, w_val);
      end
      settings++;

      case ($urandom_range(0, 2))
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 15; rx_idle_pct = 15; end
        default: begin tx_idle_pct = 40; rx_idle_pct = 35; end
      endcase

      total = eff_dim(reg_width) * 4 * eff_dim(reg_height);
      if (phase == 5) begin
        // Hold the output off while emits keep coming, so the block backs up.
        rx_hold_req++;
        for (int i = 0; i < 48; i++) push_beat(OP_EMIT, $urandom());
        rand_beats += 48;
      end else if (total <= 64 && $urandom_range(0, 2) != 0) begin
        // Whole frame: load it, read it back, then a little random traffic.
        for (int i = 0; i < total; i++) push_beat(OP_LOAD, $urandom());
        for (int i = 0; i < total; i++) push_beat(OP_EMIT, $urandom());
        cnt = $urandom_range(0, 8);
        for (int i = 0; i < cnt; i++)
          push_beat($urandom_range(0, 1) ? OP_EMIT : OP_LOAD, $urandom());
        rand_beats += 2 * total + cnt;
      end else begin
        cnt = $urandom_range(10, 40);
        for (int i = 0; i < cnt; i++)
          push_beat(($urandom_range(0, 99) < 35) ? OP_LOAD : OP_EMIT, $urandom());
        rand_beats += cnt;
      end
      settle();
    end

    settle();
    $display("Covered %0d loads and %0d emits over %0d register settings.", loads_taken,
             emits_taken, settings);
    $display("Emits per mode none/270/180/90: %0d/%0d/%0d/%0d, frame ends seen: %0d.",
             mode_emits[0], mode_emits[1], mode_emits[2], mode_emits[3], frame_ends);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lfr_pkg.sv
hdl/lfr_front.sv
hdl/lfr_queue.sv
hdl/lfr_back.sv
hdl/luma_frame_rotator_unit.sv
tb/sv/tb.sv
